// ----- design/btpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_pkg
// Constants shared by the barometric temperature/pressure compensation block.
// ----------------------------------------------------------------------------
package btpc_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C  = 3'd3;
    localparam int CFG_W = 48;

    // compensation constants
    localparam int TFINE_OFFSET = 128000;
    localparam int PRESS_OFFSET = 1048576;
    localparam int PRESS_SCALE  = 3125;
    localparam int TEMP_ROUND   = 128;

    // pipeline layout
    localparam int DIV_STEPS = 64;   // one quotient bit per stage
    localparam int DIV_RW    = 32;   // partial remainder width
    localparam int ST_TEMP   = 4;    // stage where the temperature result is done
    localparam int ST_DIV0   = 10;   // divider operand preparation stage
    localparam int ST_OUT    = ST_DIV0 + DIV_STEPS + 6;
    localparam int TLEN      = ST_OUT - ST_TEMP + 1;
    localparam int ZLEN      = ST_OUT - ST_DIV0 + 1;

endpackage
`default_nettype wire

// ----- design/baro_temp_pressure_compensation.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer compensation of raw barometric temperature and pressure samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_* carries one raw temperature/pressure pair per
//   transaction; output channel m_* carries the compensated temperature in
//   0.01 degC, pressure in Pa (unsigned Q24.8) and a pressure valid flag.
//   Calibration words are written through cfg_we/cfg_index/cfg_wdata while
//   no transaction is in flight; indexes above three are ignored.
//   Throughput is one transaction per cycle while the receiver keeps up;
//   the 64-stage restoring divider (one quotient bit per stage) sets the
//   depth. When the receiver stalls, the whole pipeline holds and s_ready
//   drops until the output register is taken; nothing is lost or
//   repeated. Synchronous active-low reset empties the pipeline and
//   clears the four calibration registers to zero.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation
    import btpc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // raw samples
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [19:0]          s_temp_adc,
    input  wire logic [19:0]          s_press_adc,
    // compensated results
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [15:0]        m_temperature_centi,
    output logic [31:0]               m_pressure_q24_8,
    output logic                      m_pressure_valid
);

    // ------------------------------------------------------------------
    // calibration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] cal_t_reg, cal_a_reg, cal_b_reg, cal_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_t_reg <= '0;
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TEMP_CAL: cal_t_reg <= cfg_wdata;
                CFG_PRESS_A:  cal_a_reg <= cfg_wdata;
                CFG_PRESS_B:  cal_b_reg <= cfg_wdata;
                CFG_PRESS_C:  cal_c_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = cal_t_reg[15:0];
    assign t2 = $signed(cal_t_reg[31:16]);
    assign t3 = $signed(cal_t_reg[47:32]);
    assign p1 = cal_a_reg[15:0];
    assign p2 = $signed(cal_a_reg[31:16]);
    assign p3 = $signed(cal_a_reg[47:32]);
    assign p4 = $signed(cal_b_reg[15:0]);
    assign p5 = $signed(cal_b_reg[31:16]);
    assign p6 = $signed(cal_b_reg[47:32]);
    assign p7 = $signed(cal_c_reg[15:0]);
    assign p8 = $signed(cal_c_reg[31:16]);
    assign p9 = $signed(cal_c_reg[47:32]);

    // ------------------------------------------------------------------
    // pipeline control: global advance, output register as last stage
    // ------------------------------------------------------------------
    logic              en;
    logic [ST_OUT:0]   vld_reg;

    assign en      = !vld_reg[ST_OUT] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[ST_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[ST_OUT-1:0], s_valid};
        end
    end

    // ------------------------------------------------------------------
    // stages 0..4: temperature
    // ------------------------------------------------------------------
    logic signed [17:0] ta_reg, tb_reg;
    logic [20:0]        pr_reg [0:7];
    logic signed [33:0] m1_reg;
    logic signed [35:0] bsq_reg;
    logic signed [22:0] v1t_reg;
    logic signed [37:0] m2_reg;
    logic signed [25:0] tfine_reg;
    logic signed [26:0] pv1_reg;
    logic signed [15:0] temp_line_reg [0:TLEN-1];

    logic signed [17:0] ta_next, tb_next;
    logic [20:0]        pr_next;
    logic signed [21:0] bs12;
    logic signed [29:0] tc_sum;
    logic signed [21:0] tc;
    logic signed [15:0] temp_next;

    assign ta_next = $signed({1'b0, s_temp_adc[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign tb_next = $signed({2'b0, s_temp_adc[19:4]}) - $signed({2'b0, t1});
    assign pr_next = 21'(PRESS_OFFSET) - {1'b0, s_press_adc};
    assign bs12    = 22'(bsq_reg >>> 12);
    assign tc_sum  = 30'(tfine_reg) * 30'sd5 + 30'(TEMP_ROUND);
    assign tc      = 22'(tc_sum >>> 8);

    // temperature saturation
    always_comb begin
        if (tc < -22'sd32768) begin
            temp_next = 16'sh8000;
        end else if (tc > 22'sd32767) begin
            temp_next = 16'sh7fff;
        end else begin
            temp_next = tc[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ta_reg    <= ta_next;
            tb_reg    <= tb_next;
            pr_reg[0] <= pr_next;
            for (int i = 1; i < 8; i++) begin
                pr_reg[i] <= pr_reg[i-1];
            end
            m1_reg    <= ta_reg * t2;
            bsq_reg   <= tb_reg * tb_reg;
            v1t_reg   <= 23'(m1_reg >>> 11);
            m2_reg    <= bs12 * t3;
            tfine_reg <= 26'(v1t_reg) + 26'(m2_reg >>> 14);
            pv1_reg   <= 27'(tfine_reg) - 27'(TFINE_OFFSET);
            temp_line_reg[0] <= temp_next;
            for (int i = 1; i < TLEN; i++) begin
                temp_line_reg[i] <= temp_line_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stages 5..9: pressure divisor and dividend
    // ------------------------------------------------------------------
    logic signed [53:0] sq_reg;
    logic signed [42:0] m5_reg, m2p_reg;
    logic signed [63:0] v2a_reg, v2b_reg, v1a_reg, v1b_reg;
    logic signed [63:0] v2_reg, v1x_reg;
    logic signed [63:0] m8_reg, dn_reg;
    logic signed [30:0] den_reg;
    logic signed [63:0] num_reg;

    logic signed [69:0] prod6, prod3;
    logic signed [63:0] v1x_off;
    logic signed [80:0] prod8;
    logic signed [76:0] prodn;

    assign prod6   = sq_reg * p6;
    assign prod3   = sq_reg * p3;
    assign v1x_off = 64'sh0000_8000_0000_0000 + v1x_reg;
    assign prod8   = v1x_off * $signed({1'b0, p1});
    assign prodn   = dn_reg * $signed(13'(PRESS_SCALE));

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg  <= pv1_reg * pv1_reg;
            m5_reg  <= pv1_reg * p5;
            m2p_reg <= pv1_reg * p2;
            v2a_reg <= prod6[63:0];
            v1a_reg <= prod3[63:0];
            v2b_reg <= 64'(m5_reg) <<< 17;
            v1b_reg <= 64'(m2p_reg) <<< 12;
            v2_reg  <= v2a_reg + v2b_reg + (64'(p4) <<< 35);
            v1x_reg <= (v1a_reg >>> 8) + v1b_reg;
            m8_reg  <= prod8[63:0];
            dn_reg  <= $signed({12'b0, pr_reg[7], 31'b0}) - v2_reg;
            den_reg <= 31'(m8_reg >>> 33);
            num_reg <= prodn[63:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 10 and divider: truncating signed division, one bit per stage
    // ------------------------------------------------------------------
    logic [DIV_RW-1:0] dr_reg   [0:DIV_STEPS];
    logic [63:0]       dw_reg   [0:DIV_STEPS];
    logic [DIV_RW-1:0] dub_reg  [0:DIV_STEPS];
    logic              dneg_reg [0:DIV_STEPS];
    logic              zero_line_reg [0:ZLEN-1];

    logic signed [31:0] den_ext;

    assign den_ext = 32'(den_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            dr_reg[0]   <= '0;
            dw_reg[0]   <= num_reg[63] ? 64'(-num_reg) : num_reg;
            dub_reg[0]  <= den_reg[30] ? 32'(-den_ext) : den_ext;
            dneg_reg[0] <= num_reg[63] ^ den_reg[30];
            zero_line_reg[0] <= (den_reg == '0);
            for (int i = 1; i < ZLEN; i++) begin
                zero_line_reg[i] <= zero_line_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [DIV_RW-1:0] rsh;
        logic              ge;

        assign rsh = {dr_reg[k][DIV_RW-2:0], dw_reg[k][63]};
        assign ge  = rsh >= dub_reg[k];

        always_ff @(posedge aclk) begin
            if (en) begin
                dr_reg[k+1]   <= ge ? rsh - dub_reg[k] : rsh;
                dw_reg[k+1]   <= {dw_reg[k][62:0], ge};
                dub_reg[k+1]  <= dub_reg[k];
                dneg_reg[k+1] <= dneg_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // post-division correction, saturation and output register
    // ------------------------------------------------------------------
    logic signed [63:0] pq_reg, pp1_reg, pp2_reg, pp3_reg;
    logic [63:0]        aalo_reg;
    logic [31:0]        aax_reg;
    logic signed [63:0] mp8_reg, aa_reg, v2p_reg, v2p3_reg, m9_reg, s_reg;
    logic [31:0]        press_reg;

    logic signed [63:0] pa;
    logic [63:0]        aax_full;
    logic signed [79:0] prodp8, prod9;
    logic signed [63:0] pf;
    logic [31:0]        press_next;

    assign pa       = pq_reg >>> 13;
    assign aax_full = pa[31:0] * pa[63:32];
    assign prodp8   = pq_reg * p8;
    assign prod9    = aa_reg * p9;
    assign pf       = (s_reg >>> 8) + (64'(p7) <<< 4);

    // pressure saturation, forced to zero on a zero divisor
    always_comb begin
        if (zero_line_reg[ZLEN-2] || pf[63]) begin
            press_next = '0;
        end else if (|pf[63:32]) begin
            press_next = '1;
        end else begin
            press_next = pf[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pq_reg   <= dneg_reg[DIV_STEPS] ? 64'(-dw_reg[DIV_STEPS]) : dw_reg[DIV_STEPS];
            pp1_reg  <= pq_reg;
            aalo_reg <= pa[31:0] * pa[31:0];
            aax_reg  <= aax_full[31:0];
            mp8_reg  <= prodp8[63:0];
            pp2_reg  <= pp1_reg;
            aa_reg   <= aalo_reg + {aax_reg[30:0], 33'b0};
            v2p_reg  <= mp8_reg >>> 19;
            pp3_reg  <= pp2_reg;
            v2p3_reg <= v2p_reg;
            m9_reg   <= prod9[63:0];
            s_reg    <= pp3_reg + (m9_reg >>> 25) + v2p3_reg;
            press_reg <= press_next;
        end
    end

    assign m_temperature_centi = temp_line_reg[TLEN-1];
    assign m_pressure_q24_8    = press_reg;
    assign m_pressure_valid    = !zero_line_reg[ZLEN-1];

endmodule
`default_nettype wire
